// ===== design/crc16fc_pkg.sv =====
// crc16fc_pkg: constants, codes and the byte-wide crc-16 update for the frame checker
// no dependencies
`default_nettype none

package crc16fc_pkg;

    localparam int BYTE_W    = 8;
    localparam int CRC_W     = 16;
    localparam int PAYLOAD_W = 32;
    localparam int ERR_W     = 3;
    localparam int POS_W     = 4;
    localparam int ACC_W     = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_START = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_TYPE  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_CRC   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_END   = 3'd4;

    localparam logic [ACC_W-1:0] ACC_NARROW_ONLY = 2'd0;
    localparam logic [ACC_W-1:0] ACC_WIDE_ONLY   = 2'd1;
    localparam logic [ACC_W-1:0] ACC_BOTH        = 2'd2;

    localparam logic [BYTE_W-1:0] TYPE_NARROW = 8'h01;
    localparam logic [BYTE_W-1:0] TYPE_WIDE   = 8'h00;

    localparam logic [POS_W-1:0] POS_ADDR       = 4'd2;
    localparam logic [POS_W-1:0] POS_TYPE       = 4'd3;
    localparam logic [POS_W-1:0] POS_PAYLOAD    = 4'd4;
    localparam logic [POS_W-1:0] POS_CRC_NARROW = 4'd6;
    localparam logic [POS_W-1:0] POS_CRC_WIDE   = 4'd8;

    // msb-first crc update over one byte, unrolled
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/crc16_frame_checker.sv =====
// crc16_frame_checker: byte-serial deframer with crc-16/ccitt-false check
// depends on crc16fc_pkg
//
//  channel   dir  tdata (low bit up)                            tuser
//  s_axis    in   data_byte[7:0]                                frame_start
//  m_axis    out  address, payload[31:0], error_code[2:0], pad  payload_is_wide
//  cfg       in   accepted_type[1:0] on i_cfg_wr_en             -
//
// one byte per cycle sustained while results are not stalled; a byte sits in the
// input register, then the frame state and the result register update together
// once the result side can advance. the eight-bit crc update is unrolled into
// combinational logic. reset is synchronous, active low, and leaves the block
// waiting for a frame start. a stalled result holds the input register only
// once it is also full.
`default_nettype none

module crc16_frame_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // address, payload, error_code, zero pad
    output logic             m_axis_tuser,   // payload_is_wide
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_wr_data   // accepted_type
);

    localparam int BW = crc16fc_pkg::BYTE_W;
    localparam int CW = crc16fc_pkg::CRC_W;
    localparam int PW = crc16fc_pkg::PAYLOAD_W;
    localparam int EW = crc16fc_pkg::ERR_W;
    localparam int QW = crc16fc_pkg::POS_W;
    localparam int AW = crc16fc_pkg::ACC_W;

    logic          r_in_valid;
    logic [BW-1:0] r_in_byte;
    logic          r_in_start;

    logic [QW-1:0] r_pos,     n_pos;
    logic [CW-1:0] r_crc,     n_crc;
    logic          r_wide,    n_wide;
    logic [BW-1:0] r_addr,    n_addr;
    logic [PW-1:0] r_pay,     n_pay;
    logic [BW-1:0] r_crc_lo,  n_crc_lo;
    logic          r_ignore,  n_ignore;
    logic [AW-1:0] r_acc_type;

    logic          r_out_valid;
    logic [BW-1:0] r_out_addr,  n_out_addr;
    logic [PW-1:0] r_out_pay,   n_out_pay;
    logic          r_out_wide,  n_out_wide;
    logic [EW-1:0] r_out_err,   n_out_err;
    logic          n_emit;

    logic advance;
    logic process;

    assign advance       = !r_out_valid || m_axis_tready;
    assign process       = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_err, r_out_pay, r_out_addr};
    assign m_axis_tuser  = r_out_wide;

    always_comb begin
        logic [QW-1:0] pos;
        logic [QW-1:0] crc_pos;
        logic [CW-1:0] crc;
        logic          ok;
        logic [1:0]    lane;

        n_pos    = r_pos;
        n_crc    = r_crc;
        n_wide   = r_wide;
        n_addr   = r_addr;
        n_pay    = r_pay;
        n_crc_lo = r_crc_lo;
        n_ignore = r_ignore;
        n_emit   = 1'b0;
        n_out_err = crc16fc_pkg::ERR_OK;
        ok       = 1'b1;
        lane     = 2'd0;

        if (r_in_start) begin
            n_pos    = '0;
            n_crc    = crc16fc_pkg::CRC_INIT;
            n_wide   = 1'b0;
            n_addr   = '0;
            n_pay    = '0;
            n_crc_lo = '0;
            n_ignore = 1'b0;
        end

        pos     = n_pos;
        crc     = crc16fc_pkg::crc_byte(n_crc, r_in_byte);
        crc_pos = n_wide ? crc16fc_pkg::POS_CRC_WIDE : crc16fc_pkg::POS_CRC_NARROW;

        if (!n_ignore) begin
            n_pos = pos + 1'b1;
            if (pos < crc16fc_pkg::POS_ADDR) begin
                if (r_in_byte != '0) begin
                    n_emit    = 1'b1;
                    n_out_err = crc16fc_pkg::ERR_BAD_START;
                end else begin
                    n_crc = crc;
                end
            end else if (pos == crc16fc_pkg::POS_ADDR) begin
                n_addr = r_in_byte;
                n_crc  = crc;
            end else if (pos == crc16fc_pkg::POS_TYPE) begin
                if (r_in_byte == crc16fc_pkg::TYPE_NARROW) begin
                    n_wide = 1'b0;
                    ok     = (r_acc_type != crc16fc_pkg::ACC_WIDE_ONLY);
                end else if (r_in_byte == crc16fc_pkg::TYPE_WIDE) begin
                    n_wide = 1'b1;
                    ok     = (r_acc_type != crc16fc_pkg::ACC_NARROW_ONLY);
                end else begin
                    ok = 1'b0;
                end
                if (!ok) begin
                    n_emit    = 1'b1;
                    n_out_err = crc16fc_pkg::ERR_BAD_TYPE;
                end else begin
                    n_crc = crc;
                end
            end else if (pos < crc_pos) begin
                lane = pos[1:0] - crc16fc_pkg::POS_PAYLOAD[1:0];
                case (lane)
                    2'd0:    n_pay[7:0]   = n_pay[7:0]   | r_in_byte;
                    2'd1:    n_pay[15:8]  = n_pay[15:8]  | r_in_byte;
                    2'd2:    n_pay[23:16] = n_pay[23:16] | r_in_byte;
                    default: n_pay[31:24] = n_pay[31:24] | r_in_byte;
                endcase
                n_crc = crc;
            end else if (pos == crc_pos) begin
                n_crc_lo = r_in_byte;
            end else if (pos == crc_pos + 4'd1) begin
                if ({r_in_byte, n_crc_lo} != n_crc) begin
                    n_emit    = 1'b1;
                    n_out_err = crc16fc_pkg::ERR_BAD_CRC;
                end
            end else if (pos == crc_pos + 4'd2) begin
                if (r_in_byte != '0) begin
                    n_emit    = 1'b1;
                    n_out_err = crc16fc_pkg::ERR_BAD_END;
                end
            end else begin
                n_emit    = 1'b1;
                n_out_err = (r_in_byte != '0) ? crc16fc_pkg::ERR_BAD_END
                                              : crc16fc_pkg::ERR_OK;
            end
        end

        if (n_emit) begin
            n_ignore = 1'b1;
        end
        n_out_addr = n_addr;
        n_out_pay  = (n_out_err == crc16fc_pkg::ERR_OK) ? n_pay : '0;
        n_out_wide = n_wide;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_crc       <= crc16fc_pkg::CRC_INIT;
            r_wide      <= 1'b0;
            r_addr      <= '0;
            r_pay       <= '0;
            r_crc_lo    <= '0;
            r_ignore    <= 1'b1;
            r_acc_type  <= crc16fc_pkg::ACC_BOTH;
        end else begin
            if (i_cfg_wr_en) begin
                r_acc_type <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= process && n_emit;
            end
            if (process) begin
                r_pos    <= n_pos;
                r_crc    <= n_crc;
                r_wide   <= n_wide;
                r_addr   <= n_addr;
                r_pay    <= n_pay;
                r_crc_lo <= n_crc_lo;
                r_ignore <= n_ignore;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
        if (process && n_emit) begin
            r_out_addr <= n_out_addr;
            r_out_pay  <= n_out_pay;
            r_out_wide <= n_out_wide;
            r_out_err  <= n_out_err;
        end
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench for crc16_frame_checker: byte frames go in, deframed results are checked
// against a scoreboard that recomputes the crc-16 and the frame state per byte
// depends on crc16fc_pkg and the crc16_frame_checker rtl
`default_nettype none

module testbench;

    localparam logic [crc16fc_pkg::ACC_W-1:0] ACC_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 240;

    typedef struct packed {
        logic [7:0]  addr;
        logic [31:0] payload;
        logic        wide;
        logic [2:0]  code;
    } t_frame_result;

    class t_frame_result_board;
        t_frame_result awaited[$];
        int failures;
        logic [3:0]  pos_next;
        logic [15:0] crc_run;
        logic        wide;
        logic [7:0]  addr;
        logic [31:0] collected;
        logic [7:0]  crc_low;
        logic        skipping;
        logic        bad_end;
        logic [1:0]  type_mode;

        function new();
            restart();
            skipping = 1'b1;
            type_mode = crc16fc_pkg::ACC_BOTH;
            failures = 0;
        endfunction

        static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ b[i];
                c = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ crc16fc_pkg::CRC_POLY;
                end
            end
            return c;
        endfunction

        function void restart();
            pos_next = '0;
            crc_run = crc16fc_pkg::CRC_INIT;
            wide = 1'b0;
            addr = '0;
            collected = '0;
            crc_low = '0;
            bad_end = 1'b0;
        endfunction

        function void set_mode(logic [1:0] m);
            type_mode = m;
        endfunction

        function void post(logic [2:0] code);
            awaited.push_back('{addr, (code == crc16fc_pkg::ERR_OK) ? collected : 32'h0,
                                wide, code});
            skipping = 1'b1;
        endfunction

        function void take_byte(logic [7:0] b, logic st);
            logic [3:0] p;
            logic [3:0] crc_at;
            logic ok;
            if (st) begin
                restart();
                skipping = 1'b0;
            end else if (skipping) begin
                return;
            end
            p = pos_next;
            crc_at = wide ? crc16fc_pkg::POS_CRC_WIDE : crc16fc_pkg::POS_CRC_NARROW;
            pos_next = pos_next + 4'd1;
            if (p < crc16fc_pkg::POS_ADDR) begin
                if (b != 8'h00) begin
                    post(crc16fc_pkg::ERR_BAD_START);
                    return;
                end
                crc_run = crc_next(crc_run, b);
            end else if (p == crc16fc_pkg::POS_ADDR) begin
                addr = b;
                crc_run = crc_next(crc_run, b);
            end else if (p == crc16fc_pkg::POS_TYPE) begin
                ok = 1'b0;
                if (b == crc16fc_pkg::TYPE_NARROW) begin
                    wide = 1'b0;
                    ok = (type_mode != crc16fc_pkg::ACC_WIDE_ONLY);
                end else if (b == crc16fc_pkg::TYPE_WIDE) begin
                    wide = 1'b1;
                    ok = (type_mode != crc16fc_pkg::ACC_NARROW_ONLY);
                end
                if (!ok) begin
                    post(crc16fc_pkg::ERR_BAD_TYPE);
                    return;
                end
                crc_run = crc_next(crc_run, b);
            end else if (p < crc_at) begin
                collected = collected | (32'(b) << (8 * (p - crc16fc_pkg::POS_PAYLOAD)));
                crc_run = crc_next(crc_run, b);
            end else if (p == crc_at) begin
                crc_low = b;
            end else if (p == crc_at + 4'd1) begin
                if ({b, crc_low} != crc_run) begin
                    post(crc16fc_pkg::ERR_BAD_CRC);
                end
            end else if (p == crc_at + 4'd2) begin
                if (b != 8'h00) begin
                    bad_end = 1'b1;
                    post(crc16fc_pkg::ERR_BAD_END);
                end
            end else begin
                if (b != 8'h00) begin
                    bad_end = 1'b1;
                    post(crc16fc_pkg::ERR_BAD_END);
                end else begin
                    post(crc16fc_pkg::ERR_OK);
                end
            end
        endfunction

        function void check_result(logic [47:0] d, logic u);
            t_frame_result want;
            t_frame_result got;
            got = '{d[7:0], d[39:8], u, d[42:40]};
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result: addr %h payload %h wide %b code %0d",
                             got.addr, got.payload, got.wide, got.code);
                end
                return;
            end
            want = awaited.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: expected addr %h payload %h wide %b code %0d",
                             want.addr, want.payload, want.wide, want.code);
                    $display("          actual   addr %h payload %h wide %b code %0d",
                             got.addr, got.payload, got.wide, got.code);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // data_byte
    logic        s_axis_tuser = 1'b0; // frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // address, payload, error_code, zero pad
    logic        m_axis_tuser;        // payload_is_wide
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_wr_data = crc16fc_pkg::ACC_BOTH;

    t_frame_result_board board = new();
    logic [7:0] frame_bytes[$];
    int sent_bytes = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    crc16_frame_checker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 32'h0;
        end
        if (r == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    function automatic void build_frame(logic [7:0] address, logic [7:0] kind,
                                        logic [31:0] word);
        logic [15:0] c;
        int n;
        frame_bytes = {8'h00, 8'h00, address, kind};
        n = (kind == crc16fc_pkg::TYPE_WIDE) ? 4 : 2;
        for (int i = 0; i < n; i++) begin
            frame_bytes.push_back(word[8*i +: 8]);
        end
        c = crc16fc_pkg::CRC_INIT;
        foreach (frame_bytes[i]) begin
            c = t_frame_result_board::crc_next(c, frame_bytes[i]);
        end
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
    endfunction

    // called at a rising edge, returns at the edge where the word is taken
    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        gap = pick_gap(send_idle_pct);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= st;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.take_byte(b, st);
    endtask

    task automatic send_frame(input int upto);
        for (int i = 0; i < upto; i++) begin
            send_byte(frame_bytes[i], i == 0);
        end
        sent_bytes += upto;
    endtask

    task automatic write_accepted_type(input logic [1:0] v);
        s_axis_tvalid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.set_mode(v);
    endtask

    task automatic random_frame();
        logic [7:0] kind;
        int roll;
        int idx;
        int cut;
        roll = $urandom_range(0, 99);
        kind = $urandom_range(0, 1) ? crc16fc_pkg::TYPE_WIDE : crc16fc_pkg::TYPE_NARROW;
        build_frame(8'($urandom), kind, pick_word());
        cut = frame_bytes.size();
        if (roll < 25) begin
            idx = $urandom_range(0, frame_bytes.size() - 1);
            frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
        end else if (roll < 32) begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
        end
        if ($urandom_range(0, 5) == 0) begin
            send_idle_pct = $urandom_range(0, 2) * 20;
            sink_stall_pct <= $urandom_range(0, 2) * 25;
        end
        // stray words between frames
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        end
        send_frame(cut);
    endtask

    task automatic random_phase();
        int goal;
        goal = sent_bytes + PHASE_BYTES;
        while (sent_bytes < goal) begin
            random_frame();
        end
    endtask

    always @(posedge i_clk) begin : sink_side
        int g;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata, m_axis_tuser);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else begin
            g = pick_gap(sink_stall_pct);
            stall_left <= g;
            m_axis_tready <= (g == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // good frames at the field extremes
        build_frame(8'hFF, crc16fc_pkg::TYPE_NARROW, 32'h0000FFFF);
        send_frame(frame_bytes.size());
        build_frame(8'h00, crc16fc_pkg::TYPE_WIDE, 32'hFFFFFFFF);
        send_frame(frame_bytes.size());
        // bad first and second start byte
        build_frame(8'hA5, crc16fc_pkg::TYPE_WIDE, 32'h0);
        frame_bytes[0] = 8'h80;
        send_frame(1);
        frame_bytes[0] = 8'h00;
        frame_bytes[1] = 8'h01;
        send_frame(2);
        // unknown type
        build_frame(8'h3C, 8'h02, 32'h0);
        send_frame(4);
        // crc mismatch
        build_frame(8'h5A, crc16fc_pkg::TYPE_NARROW, 32'h00001234);
        frame_bytes[6] = frame_bytes[6] ^ 8'h01;
        send_frame(frame_bytes.size());
        // bad first end byte, then bad last end byte
        build_frame(8'h81, crc16fc_pkg::TYPE_NARROW, 32'h0000BEEF);
        frame_bytes[8] = 8'h40;
        send_frame(frame_bytes.size());
        build_frame(8'h18, crc16fc_pkg::TYPE_WIDE, 32'h01020304);
        frame_bytes[11] = 8'h01;
        send_frame(frame_bytes.size());
        // word while waiting for a start
        send_byte(8'hFF, 1'b0);
        // restart in the middle of a frame
        build_frame(8'h77, crc16fc_pkg::TYPE_WIDE, 32'hCAFEF00D);
        send_frame(5);
        build_frame(8'h42, crc16fc_pkg::TYPE_NARROW, 32'h00008001);
        send_frame(frame_bytes.size());

        random_phase();

        write_accepted_type(crc16fc_pkg::ACC_NARROW_ONLY);
        build_frame(8'h11, crc16fc_pkg::TYPE_WIDE, 32'h12345678);
        send_frame(frame_bytes.size());
        random_phase();

        write_accepted_type(crc16fc_pkg::ACC_WIDE_ONLY);
        build_frame(8'h22, crc16fc_pkg::TYPE_NARROW, 32'h00005678);
        send_frame(frame_bytes.size());
        random_phase();

        write_accepted_type(ACC_UNUSED);
        random_phase();

        write_accepted_type(crc16fc_pkg::ACC_BOTH);
        random_phase();

        s_axis_tvalid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.failures == 0 && board.awaited.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
